FILE: src/sld_pkg.sv
package sld_pkg;

  localparam int COS_TABLE_DEPTH = 256;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_START_HEIGHT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_END_HEIGHT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DAMPING_RATE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_U_SLOPE      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_U_OFFSET     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_V_SLOPE      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_V_OFFSET     = 3'd6;

  localparam logic [15:0] COEF_ONE = 16'h8000;

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint PI_Q30  = 64'sd3373259426;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return 32'(v);
    end
  endfunction

endpackage

FILE: src/sld_div.sv
module sld_div #(
  parameter int NW = 42,
  parameter int DW = 32,
  parameter int QW = 9
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [NW-1:0] rem [0:QW-1];
  logic [DW-1:0] dd  [0:QW-1];
  logic [QW-1:0] qq  [0:QW];

  assign rem[0] = num;
  assign dd[0] = den;
  assign qq[0] = '0;

  // one quotient bit per stage, msb first
  for (genvar g = 0; g < QW; g++) begin : g_step
    localparam int J = QW - 1 - g;
    logic [NW-1:0] sh;
    logic          ge;
    assign sh = NW'(dd[g]) << J;
    assign ge = rem[g] >= sh;

    always_ff @(posedge clk) begin
      qq[g+1] <= {qq[g][QW-2:0], ge};
    end

    if (g < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem[g+1] <= ge ? rem[g] - sh : rem[g];
        dd[g+1] <= dd[g];
      end
    end
  end

  assign quo = qq[QW];

endmodule

FILE: src/sponge_layer_velocity_damping.sv
// start passes through stage a, stage b, the divider stages, stage k, stage t and the output register to done
// throughput: one item per cycle; busy stays low, start is taken every cycle
// the pipeline depth is set by the restoring taper-index divider, one quotient bit a stage
// done is a one-cycle strobe; the receiver cannot stall the pipeline
// rst (synchronous) clears the configuration registers to 0 and empties the pipeline
module sponge_layer_velocity_damping #(
  parameter int COS_TABLE_DEPTH = sld_pkg::COS_TABLE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cfg_wr,
  input  logic [sld_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sld_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [31:0]               centre_height,
  input  logic signed [31:0]               face_height,
  input  logic signed [31:0]               u_vel,
  input  logic signed [31:0]               v_vel,
  input  logic signed [31:0]               w_vel,
  input  logic signed [31:0]               fx_in,
  input  logic signed [31:0]               fy_in,
  input  logic signed [31:0]               fz_in,
  output logic                             done,
  output logic signed [31:0]               fx_out,
  output logic signed [31:0]               fy_out,
  output logic signed [31:0]               fz_out
);

  localparam int QW = $clog2(COS_TABLE_DEPTH + 1);
  localparam int NW = 33 + QW;
  localparam int LAT = QW + 5;
  localparam int TW = 16 * (COS_TABLE_DEPTH + 1);

  // q1.15 value of (1 + cos(pi*i/depth))/2 per entry, integer taylor series
  function automatic logic [TW-1:0] taper_table();
    logic [TW-1:0] tab;
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint c;
    tab = '0;
    for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
      if (2 * i <= COS_TABLE_DEPTH) begin
        x = sld_pkg::PI_Q30 * longint'(i) / COS_TABLE_DEPTH;
        x2 = x * x / sld_pkg::Q30_ONE;
        term = sld_pkg::Q30_ONE;
        sum = sld_pkg::Q30_ONE;
        term = -(term * x2 / sld_pkg::Q30_ONE) / 64'sd2;
        sum = sum + term;
        term = -(term * x2 / sld_pkg::Q30_ONE) / 64'sd12;
        sum = sum + term;
        term = -(term * x2 / sld_pkg::Q30_ONE) / 64'sd30;
        sum = sum + term;
        term = -(term * x2 / sld_pkg::Q30_ONE) / 64'sd56;
        sum = sum + term;
        term = -(term * x2 / sld_pkg::Q30_ONE) / 64'sd90;
        sum = sum + term;
        term = -(term * x2 / sld_pkg::Q30_ONE) / 64'sd132;
        sum = sum + term;
        term = -(term * x2 / sld_pkg::Q30_ONE) / 64'sd182;
        sum = sum + term;
        term = -(term * x2 / sld_pkg::Q30_ONE) / 64'sd240;
        sum = sum + term;
        term = -(term * x2 / sld_pkg::Q30_ONE) / 64'sd306;
        sum = sum + term;
        term = -(term * x2 / sld_pkg::Q30_ONE) / 64'sd380;
        sum = sum + term;
        c = (sld_pkg::Q30_ONE + sum + 64'sd32768) / 64'sd65536;
        if (c < 0) c = 0;
        if (c > 64'sd32768) c = 64'sd32768;
        tab[16*i +: 16] = 16'(c);
      end else begin
        tab[16*i +: 16] = sld_pkg::COEF_ONE - tab[16*(COS_TABLE_DEPTH-i) +: 16];
      end
    end
    return tab;
  endfunction

  localparam logic [TW-1:0] TAPER_TAB = taper_table();

  typedef struct packed {
    logic damp_h;
    logic taper_h;
    logic damp_v;
    logic taper_v;
  } flags_t;

  typedef struct packed {
    flags_t             fl;
    logic signed [31:0] dev_u;
    logic signed [31:0] dev_v;
    logic signed [31:0] w;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
  } pay_t;

  logic signed [31:0] start_height, end_height;
  logic [30:0]        damping_rate;
  logic signed [31:0] u_slope, u_offset, v_slope, v_offset;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_height <= '0;
      end_height <= '0;
      damping_rate <= '0;
      u_slope <= '0;
      u_offset <= '0;
      v_slope <= '0;
      v_offset <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        sld_pkg::REG_START_HEIGHT: start_height <= cfg_data;
        sld_pkg::REG_END_HEIGHT:   end_height <= cfg_data;
        sld_pkg::REG_DAMPING_RATE: damping_rate <= cfg_data[30:0];
        sld_pkg::REG_U_SLOPE:      u_slope <= cfg_data;
        sld_pkg::REG_U_OFFSET:     u_offset <= cfg_data;
        sld_pkg::REG_V_SLOPE:      v_slope <= cfg_data;
        sld_pkg::REG_V_OFFSET:     v_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [15:0] tab_rom [0:COS_TABLE_DEPTH];
  for (genvar g = 0; g <= COS_TABLE_DEPTH; g++) begin : g_tab
    assign tab_rom[g] = TAPER_TAB[16*g +: 16];
  end

  // stage a: region flags, distances, background products
  logic               up;
  flags_t             fl_a;
  logic signed [32:0] dh, dv, ds;
  assign up = start_height < end_height;
  assign fl_a.damp_h = up ? (centre_height > start_height) : (centre_height < start_height);
  assign fl_a.taper_h = up ? (centre_height < end_height) : (centre_height > end_height);
  assign fl_a.damp_v = up ? (face_height >= start_height)
                          : ((start_height > end_height) && (face_height <= start_height));
  assign fl_a.taper_v = up ? (face_height <= end_height) : (face_height >= end_height);
  assign dh = 33'(centre_height) - 33'(end_height);
  assign dv = 33'(face_height) - 33'(end_height);
  assign ds = 33'(end_height) - 33'(start_height);

  logic               a_vld;
  flags_t             a_fl;
  logic [31:0]        a_udh, a_udv, a_us;
  logic signed [63:0] a_prod_u, a_prod_v;
  logic signed [31:0] a_u, a_v, a_w, a_fx, a_fy, a_fz;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_fl <= fl_a;
    a_udh <= dh[32] ? 32'(-dh) : dh[31:0];
    a_udv <= dv[32] ? 32'(-dv) : dv[31:0];
    a_us <= ds[32] ? 32'(-ds) : ds[31:0];
    a_prod_u <= 64'(u_slope) * 64'(centre_height);
    a_prod_v <= 64'(v_slope) * 64'(centre_height);
    a_u <= u_vel;
    a_v <= v_vel;
    a_w <= w_vel;
    a_fx <= fx_in;
    a_fy <= fy_in;
    a_fz <= fz_in;
  end

  // stage b: divider numerators and deviations
  logic signed [49:0] sum_u, sum_v;
  assign sum_u = 50'(a_u) - 50'(u_offset) - 50'(a_prod_u >>> 16);
  assign sum_v = 50'(a_v) - 50'(v_offset) - 50'(a_prod_v >>> 16);

  logic [NW-1:0] b_num_h, b_num_v;
  logic [31:0]   b_us;
  pay_t          dl [0:QW];
  logic [QW:0]   dl_vld;

  always_ff @(posedge clk) begin
    b_num_h <= NW'(a_udh) * NW'(COS_TABLE_DEPTH) + NW'(a_us[31:1]);
    b_num_v <= NW'(a_udv) * NW'(COS_TABLE_DEPTH) + NW'(a_us[31:1]);
    b_us <= a_us;
    dl[0].fl <= a_fl;
    dl[0].dev_u <= sld_pkg::sat32(64'(sum_u));
    dl[0].dev_v <= sld_pkg::sat32(64'(sum_v));
    dl[0].w <= a_w;
    dl[0].fx <= a_fx;
    dl[0].fy <= a_fy;
    dl[0].fz <= a_fz;
    for (int i = 1; i <= QW; i++) begin
      dl[i] <= dl[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dl_vld <= '0;
    end else begin
      dl_vld <= {dl_vld[QW-1:0], a_vld};
    end
  end

  logic [QW-1:0] quo_h, quo_v;

  sld_div #(.NW(NW), .DW(32), .QW(QW)) u_div_h (
    .clk (clk),
    .num (b_num_h),
    .den (b_us),
    .quo (quo_h)
  );

  sld_div #(.NW(NW), .DW(32), .QW(QW)) u_div_v (
    .clk (clk),
    .num (b_num_v),
    .den (b_us),
    .quo (quo_v)
  );

  // stage k: taper lookup and scaled coefficient
  logic [QW-1:0] idx_h, idx_v;
  logic [15:0]   c_h, c_v;
  assign idx_h = (quo_h > QW'(COS_TABLE_DEPTH)) ? QW'(COS_TABLE_DEPTH) : quo_h;
  assign idx_v = (quo_v > QW'(COS_TABLE_DEPTH)) ? QW'(COS_TABLE_DEPTH) : quo_v;
  assign c_h = dl[QW].fl.taper_h ? tab_rom[idx_h] : sld_pkg::COEF_ONE;
  assign c_v = dl[QW].fl.taper_v ? tab_rom[idx_v] : sld_pkg::COEF_ONE;

  logic        k_vld;
  pay_t        k_pay;
  logic [30:0] k_h, k_v;
  logic [46:0] kp_h, kp_v;
  assign kp_h = 47'(c_h) * 47'(damping_rate);
  assign kp_v = 47'(c_v) * 47'(damping_rate);

  always_ff @(posedge clk) begin
    if (rst) begin
      k_vld <= 1'b0;
    end else begin
      k_vld <= dl_vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    k_pay <= dl[QW];
    k_h <= dl[QW].fl.damp_h ? kp_h[45:15] : '0;
    k_v <= dl[QW].fl.damp_v ? kp_v[45:15] : '0;
  end

  // stage t: damping terms
  logic signed [63:0] pr_x, pr_y, pr_z;
  assign pr_x = 64'($signed({1'b0, k_h})) * 64'(k_pay.dev_u);
  assign pr_y = 64'($signed({1'b0, k_h})) * 64'(k_pay.dev_v);
  assign pr_z = 64'($signed({1'b0, k_v})) * 64'(k_pay.w);

  logic               t_vld;
  logic signed [31:0] t_fx, t_fy, t_fz;
  logic signed [46:0] t_term_x, t_term_y, t_term_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      t_vld <= 1'b0;
    end else begin
      t_vld <= k_vld;
    end
  end

  always_ff @(posedge clk) begin
    t_fx <= k_pay.fx;
    t_fy <= k_pay.fy;
    t_fz <= k_pay.fz;
    t_term_x <= 47'(pr_x >>> 16);
    t_term_y <= 47'(pr_y >>> 16);
    t_term_z <= 47'(pr_z >>> 16);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= t_vld;
    end
  end

  always_ff @(posedge clk) begin
    fx_out <= sld_pkg::sat32(64'(t_fx) - 64'(t_term_x));
    fy_out <= sld_pkg::sat32(64'(t_fy) - 64'(t_term_y));
    fz_out <= sld_pkg::sat32(64'(t_fz) - 64'(t_term_z));
  end

`ifndef SYNTHESIS
  a_item_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted item produced no result");

  a_done_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without accepted item");

  a_no_damp_z: assert property (@(posedge clk) disable iff (rst)
    (k_vld && !k_pay.fl.damp_v) |=> (t_term_z == '0))
    else $error("vertical term nonzero outside sponge");
`endif

endmodule

FILE: bench/tb_sponge_layer_velocity_damping.sv
module tb_sponge_layer_velocity_damping;

  localparam int DEPTH = 256;
  localparam int LATENCY = 14;
  localparam longint LIMIT = 400000;
  localparam logic [sld_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
  } force_t;

  class force_scoreboard;
    force_t pending[$];
    int errors;

    function void note(force_t f);
      pending.push_back(f);
    endfunction

    function void check(force_t got);
      force_t want;
      if (pending.size() == 0) begin
        $error("unexpected result fx=%h fy=%h fz=%h", got.fx, got.fy, got.fz);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.fx !== want.fx) begin
        $error("fx_out expected %h actual %h", want.fx, got.fx);
        errors++;
      end
      if (got.fy !== want.fy) begin
        $error("fy_out expected %h actual %h", want.fy, got.fy);
        errors++;
      end
      if (got.fz !== want.fz) begin
        $error("fz_out expected %h actual %h", want.fz, got.fz);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic cfg_wr = 0;
  logic [sld_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [sld_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic signed [31:0] centre_height = 0, face_height = 0, u_vel = 0, v_vel = 0;
  logic signed [31:0] w_vel = 0, fx_in = 0, fy_in = 0, fz_in = 0;
  logic done;
  logic signed [31:0] fx_out, fy_out, fz_out;

  sponge_layer_velocity_damping DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .centre_height(centre_height), .face_height(face_height),
    .u_vel(u_vel), .v_vel(v_vel), .w_vel(w_vel),
    .fx_in(fx_in), .fy_in(fy_in), .fz_in(fz_in),
    .done(done), .fx_out(fx_out), .fy_out(fy_out), .fz_out(fz_out)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  force_scoreboard sb = new();
  longint taper_lut[DEPTH+1];
  longint z_start, z_end, rate, us, uo, vs, vo;
  longint cycles = 0;
  bit quiet = 0;

  always @(posedge clk) begin
    force_t r;
    cycles++;
    if (!rst && done) begin
      r.fx = fx_out;
      r.fy = fy_out;
      r.fz = fz_out;
      sb.check(r);
    end
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void build_lut();
    longint x, x2, term, sum, c;
    for (int i = 0; i <= DEPTH; i++) begin
      if (2 * i <= DEPTH) begin
        x = 64'sd3373259426 * i / DEPTH;
        x2 = x * x / 64'sd1073741824;
        term = 64'sd1073741824;
        sum = term;
        for (int k = 1; k <= 10; k++) begin
          term = -(term * x2 / 64'sd1073741824) / ((2 * k - 1) * (2 * k));
          sum += term;
        end
        c = (64'sd1073741824 + sum + 32768) / 65536;
        if (c < 0) c = 0;
        if (c > 32768) c = 32768;
        taper_lut[i] = c;
      end else begin
        taper_lut[i] = 32768 - taper_lut[DEPTH - i];
      end
    end
  endfunction

  function automatic longint taper_coef(longint z);
    longint d, sp, idx;
    d = z - z_end;
    sp = z_end - z_start;
    if (d < 0) d = -d;
    if (sp < 0) sp = -sp;
    if (sp == 0) return 32768;
    idx = (d * DEPTH + sp / 2) / sp;
    if (idx > DEPTH) idx = DEPTH;
    return taper_lut[idx];
  endfunction

  function automatic longint damp_force(longint f, longint k, longint dev);
    return clamp32(f - floor_sh(k * clamp32(dev), 16));
  endfunction

  function automatic force_t predict_force(longint zc, longint zf, longint u, longint v,
                                           longint w, longint fx, longint fy, longint fz);
    force_t r;
    longint c, k;
    bit up;
    up = z_start < z_end;
    if ((up && zc > z_start) || (!up && zc < z_start)) begin
      c = 32768;
      if ((up && zc < z_end) || (!up && zc > z_end)) c = taper_coef(zc);
      k = floor_sh(c * rate, 15);
      fx = damp_force(fx, k, u - uo - floor_sh(us * zc, 16));
      fy = damp_force(fy, k, v - vo - floor_sh(vs * zc, 16));
    end
    if ((up && zf >= z_start) || (z_start > z_end && zf <= z_start)) begin
      c = 32768;
      if ((up && zf <= z_end) || (z_start > z_end && zf >= z_end)) c = taper_coef(zf);
      k = floor_sh(c * rate, 15);
      fz = damp_force(fz, k, w);
    end
    r.fx = 32'(fx);
    r.fy = 32'(fy);
    r.fz = 32'(fz);
    return r;
  endfunction

  task automatic write_reg(logic [sld_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] val);
    cfg_wr <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    unique case (idx)
      sld_pkg::REG_START_HEIGHT: z_start = longint'($signed(val));
      sld_pkg::REG_END_HEIGHT: z_end = longint'($signed(val));
      sld_pkg::REG_DAMPING_RATE: rate = longint'(val[30:0]);
      sld_pkg::REG_U_SLOPE: us = longint'($signed(val));
      sld_pkg::REG_U_OFFSET: uo = longint'($signed(val));
      sld_pkg::REG_V_SLOPE: vs = longint'($signed(val));
      sld_pkg::REG_V_OFFSET: vo = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_wr <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] zc, logic [31:0] zf, logic [31:0] u,
                            logic [31:0] v, logic [31:0] w, logic [31:0] fx,
                            logic [31:0] fy, logic [31:0] fz);
    while (!quiet && $urandom_range(99) < 28) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    centre_height <= zc; face_height <= zf;
    u_vel <= u; v_vel <= v; w_vel <= w;
    fx_in <= fx; fy_in <= fy; fz_in <= fz;
    do @(posedge clk); while (busy);
    sb.note(predict_force($signed(zc), $signed(zf), $signed(u), $signed(v),
                          $signed(w), $signed(fx), $signed(fy), $signed(fz)));
  endtask

  task automatic stop_sending();
    start <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_height();
    longint span;
    span = z_end >= z_start ? z_end - z_start : z_start - z_end;
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'(z_start + longint'($urandom_range(16, 0)) - 8);
      2: return 32'(z_end + longint'($urandom_range(16, 0)) - 8);
      default: return 32'(z_start + (z_end >= z_start ? 64'sd1 : -64'sd1)
                          * longint'($urandom % (span + 1)));
    endcase
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(32'h40000)) - 32'sh20000;
    endcase
  endfunction

  task automatic random_config(int mode);
    logic [31:0] a, b;
    a = $signed($urandom_range(32'h200000)) - 32'sh100000;
    b = $signed($urandom_range(32'h200000)) - 32'sh100000;
    case (mode)
      0: begin a = 32'h80000000; b = 32'h7fffffff; end
      1: begin a = 32'h7fffffff; b = 32'h80000000; end
      2: b = a;
      3: b = a + 32'h100;
      default: ;
    endcase
    write_reg(sld_pkg::REG_START_HEIGHT, a);
    write_reg(sld_pkg::REG_END_HEIGHT, b);
    write_reg(sld_pkg::REG_DAMPING_RATE, mode == 0 ? 32'h7fffffff :
              (mode == 1 ? 32'h0 : $urandom_range(32'h40000)));
    write_reg(sld_pkg::REG_U_SLOPE, mode < 2 ? 32'h80000000 : rand_val());
    write_reg(sld_pkg::REG_U_OFFSET, mode < 2 ? 32'h7fffffff : rand_val());
    write_reg(sld_pkg::REG_V_SLOPE, mode < 2 ? 32'h7fffffff : rand_val());
    write_reg(sld_pkg::REG_V_OFFSET, mode < 2 ? 32'h80000000 : rand_val());
    write_reg(REG_UNUSED, $urandom);
    end_writes();
  endtask

  initial begin
    z_start = 0; z_end = 0; rate = 0; us = 0; uo = 0; vs = 0; vo = 0;
    build_lut();
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    write_reg(sld_pkg::REG_START_HEIGHT, 32'h0001_0000);
    write_reg(sld_pkg::REG_END_HEIGHT, 32'h0005_0000);
    write_reg(sld_pkg::REG_DAMPING_RATE, 32'h0001_0000);
    write_reg(sld_pkg::REG_U_SLOPE, 32'h0000_8000);
    write_reg(sld_pkg::REG_U_OFFSET, 32'h0000_1000);
    write_reg(sld_pkg::REG_V_SLOPE, 32'hffff_8000);
    write_reg(sld_pkg::REG_V_OFFSET, 32'hffff_f000);
    end_writes();
    send_point(32'h0000_0000, 32'h0000_0000, 1, 2, 3, 4, 5, 6);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0);
    send_point(32'h0001_0001, 32'h0000_ffff, 32'h20000, 32'h20000, 32'h20000, 7, 7, 7);
    send_point(32'h0003_0000, 32'h0003_0000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
               32'h80000000, 32'h7fffffff, 32'h80000000);
    send_point(32'h0005_0000, 32'h0005_0000, 32'h80000000, 32'h7fffffff, 32'h80000000,
               32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_point(32'h7fffffff, 32'h7fffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
               32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_point(32'h80000000, 32'h80000000, 32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f,
               32'hf0f0f0f0, 32'h55555555, 32'haaaaaaaa);
    stop_sending();
    drain();
    for (int m = 0; m < 3; m++) begin
      random_config(m);
      send_point(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                 32'h7fffffff, 32'h80000000, 32'h7fffffff);
      send_point(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 32'h80000000, 32'h7fffffff, 32'h80000000);
      send_point(32'(z_start), 32'(z_start), 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h80000000, 32'h80000000);
      send_point(32'(z_end), 32'(z_end), 32'h100000, 32'h100000, 32'h100000, 0, 0, 0);
      stop_sending();
      drain();
    end

    for (int phase = 0; phase < 12; phase++) begin
      random_config(phase % 6);
      quiet = (phase == 5);
      for (int n = 0; n < 140; n++) begin
        send_point(rand_height(), rand_height(), rand_val(), rand_val(), rand_val(),
                   rand_val(), rand_val(), rand_val());
      end
      quiet = 0;
      stop_sending();
      drain();
    end

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
